/* src/patd_pkg.sv */
`default_nettype none
package patd_pkg;

  // Widths of the tick timer and the event counters
  localparam int TIMER_WIDTH       = 16;
  localparam int EVENT_COUNT_WIDTH = 32;
  localparam int TOTAL_WIDTH       = 32;

  // Register field widths
  localparam int LEVEL_WIDTH = 7;
  localparam int TICKS_WIDTH = 15;
  localparam int CFG_WIDTH   = 15;

  // Full conduction level in percent
  localparam logic [LEVEL_WIDTH-1:0] FULL_LEVEL = 7'd100;

  // Reset values of the registers
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_RESET = 7'd50;
  localparam logic [TICKS_WIDTH-1:0] HALF_RESET  = 15'd8333;
  localparam logic [TICKS_WIDTH-1:0] MIN_RESET   = 15'd500;

  // Divide by 100: q = (x * DIV_MAGIC) >> DIV_SHIFT, exact for x < 2**22
  localparam int PROD_WIDTH  = LEVEL_WIDTH + TICKS_WIDTH;
  localparam int DIV_SHIFT   = 29;
  localparam int MAGIC_WIDTH = 23;
  localparam logic [MAGIC_WIDTH-1:0] DIV_MAGIC = 23'd5368710;
  localparam int QUOT_WIDTH  = 16;

  // Largest delay a timer of TIMER_WIDTH bits can hold
  localparam logic [32:0] TIMER_LIMIT = (33'd1 << TIMER_WIDTH) - 33'd1;

  // Cycles the delay pipeline needs after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  // Register indexes
  typedef enum logic [1:0] {
    REG_FIRING_LEVEL     = 2'd0,
    REG_DIMMER_ON        = 2'd1,
    REG_HALF_CYCLE_TICKS = 2'd2,
    REG_MIN_DELAY_TICKS  = 2'd3
  } reg_index_t;

endpackage
`default_nettype wire

/* src/patd_delay.sv */
`default_nettype none
module patd_delay
  import patd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [LEVEL_WIDTH-1:0] firing_level,
  input  wire logic [TICKS_WIDTH-1:0] half_cycle_ticks,
  input  wire logic [TICKS_WIDTH-1:0] min_delay_ticks,
  output logic      [TIMER_WIDTH-1:0] target_calc
);

  logic [PROD_WIDTH-1:0]             prod;
  logic [QUOT_WIDTH-1:0]             quot;
  logic [PROD_WIDTH+MAGIC_WIDTH-1:0] scaled;
  logic [32:0]                       bounded;

  // Scale the half cycle by the off share of the level
  always_ff @(posedge clk) begin
    prod <= PROD_WIDTH'(FULL_LEVEL - firing_level) * PROD_WIDTH'(half_cycle_ticks);
  end

  // Divide by 100 through the reciprocal
  assign scaled = (PROD_WIDTH+MAGIC_WIDTH)'(prod) * (PROD_WIDTH+MAGIC_WIDTH)'(DIV_MAGIC);

  always_ff @(posedge clk) begin
    quot <= scaled[DIV_SHIFT +: QUOT_WIDTH];
  end

  // Raise to the minimum delay, then clamp to the timer range
  always_comb begin
    if (QUOT_WIDTH'(min_delay_ticks) > quot) begin
      bounded = 33'(min_delay_ticks);
    end else begin
      bounded = 33'(quot);
    end
    if (bounded > TIMER_LIMIT) begin
      bounded = TIMER_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    target_calc <= TIMER_WIDTH'(bounded);
  end

endmodule
`default_nettype wire

/* src/phase_angle_triac_dimmer_top.sv */
`default_nettype none
// Phase-angle TRIAC dimmer, one channel.
// The slave channel takes one word per microsecond tick; bit 0 of s_tdata is
// the zero-crossing flag. The master channel returns one word per tick with
// the gate level, a trigger flag and the wrapping crossing and trigger counts.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while no word is in flight (the block does not enforce it).
// A word accepted on the slave channel enters the input register; its result
// is then loaded into the output register and shown on the master channel.
// One word per cycle while the receiver keeps up and no write is settling.
// The firing delay is computed from the registers by a three-stage pipeline
// (multiply, reciprocal divide by 100, clamp), so s_tready stays low
// after reset and after every register write until it has settled.
// Reset (rst, synchronous) restores register defaults, clears gate, timer
// and counters, and empties both register stages.
// When the receiver stalls, the result holds in the output register and one
// more word may wait in the input register before s_tready drops.
module phase_angle_triac_dimmer_top
  import patd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Slave channel
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [0] zero_cross, [7:1] zero
  // Master channel
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [71:0]          m_tdata,   // [0] gate_drive, [1] fired_now,
                                               // [33:2] crossing_total,
                                               // [65:34] trigger_total,
                                               // [71:66] zero
  // Register write port
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_data
);

  // Registers
  logic [LEVEL_WIDTH-1:0] firing_level;
  logic                   dimmer_on;
  logic [TICKS_WIDTH-1:0] half_cycle_ticks;
  logic [TICKS_WIDTH-1:0] min_delay_ticks;
  logic [1:0]             settle;

  // Tick state
  logic                         gate_level, gate_level_next;
  logic                         delay_armed, delay_armed_next;
  logic [TIMER_WIDTH-1:0]       elapsed_ticks, elapsed_ticks_next;
  logic [TIMER_WIDTH-1:0]       target_delay, target_delay_next;
  logic [EVENT_COUNT_WIDTH-1:0] crossing_count, crossing_count_next;
  logic [EVENT_COUNT_WIDTH-1:0] trigger_count, trigger_count_next;
  logic                         fired;

  // Pipeline stages
  logic                   in_valid;
  logic                   in_zc;
  logic                   out_valid;
  logic                   out_gate;
  logic                   out_fired;
  logic [TOTAL_WIDTH-1:0] out_cross;
  logic [TOTAL_WIDTH-1:0] out_trig;
  logic                   out_ready;
  logic                   advance;
  logic [TIMER_WIDTH-1:0] target_calc;
  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic                   partial_level;
  logic [LEVEL_WIDTH-1:0] level_in;

  patd_delay u_delay (
    .clk              (clk),
    .firing_level     (firing_level),
    .half_cycle_ticks (half_cycle_ticks),
    .min_delay_ticks  (min_delay_ticks),
    .target_calc      (target_calc)
  );

  // Handshake between the two stages
  assign out_ready = !out_valid || m_tready;
  assign advance   = in_valid && out_ready;
  assign s_tready  = (!in_valid || out_ready) && (settle == 2'd0);

  // Write registers, saturating the level, and hold off words while the
  // delay pipeline settles
  assign level_in = cfg_data[LEVEL_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      firing_level     <= LEVEL_RESET;
      dimmer_on        <= 1'b1;
      half_cycle_ticks <= HALF_RESET;
      min_delay_ticks  <= MIN_RESET;
      settle           <= SETTLE_CYCLES;
    end else if (cfg_we) begin
      settle <= SETTLE_CYCLES;
      unique case (reg_index_t'(cfg_index))
        REG_FIRING_LEVEL: begin
          firing_level <= (level_in > FULL_LEVEL) ? FULL_LEVEL : level_in;
        end
        REG_DIMMER_ON:        dimmer_on        <= cfg_data[0];
        REG_HALF_CYCLE_TICKS: half_cycle_ticks <= cfg_data[TICKS_WIDTH-1:0];
        REG_MIN_DELAY_TICKS:  min_delay_ticks  <= cfg_data[TICKS_WIDTH-1:0];
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_zc <= s_tdata[0];
    end
  end

  // Advance the tick state for the word in the input register
  assign partial_level = dimmer_on && (firing_level != '0) && (firing_level < FULL_LEVEL);
  assign elapsed_inc   = elapsed_ticks + TIMER_WIDTH'(1);

  always_comb begin
    gate_level_next     = gate_level;
    delay_armed_next    = delay_armed;
    elapsed_ticks_next  = elapsed_ticks;
    target_delay_next   = target_delay;
    crossing_count_next = crossing_count;
    trigger_count_next  = trigger_count;
    fired               = 1'b0;
    if (in_zc) begin
      crossing_count_next = crossing_count + EVENT_COUNT_WIDTH'(1);
      delay_armed_next    = 1'b0;
      elapsed_ticks_next  = '0;
      gate_level_next     = 1'b0;
      if (dimmer_on && (firing_level >= FULL_LEVEL)) begin
        gate_level_next    = 1'b1;
        trigger_count_next = trigger_count + EVENT_COUNT_WIDTH'(1);
        fired              = 1'b1;
      end else if (partial_level) begin
        target_delay_next = target_calc;
        delay_armed_next  = 1'b1;
      end
    end else if (delay_armed) begin
      elapsed_ticks_next = elapsed_inc;
      if (elapsed_inc >= target_delay) begin
        delay_armed_next = 1'b0;
        if (partial_level) begin
          gate_level_next    = 1'b1;
          trigger_count_next = trigger_count + EVENT_COUNT_WIDTH'(1);
          fired              = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_level     <= 1'b0;
      delay_armed    <= 1'b0;
      elapsed_ticks  <= '0;
      target_delay   <= '0;
      crossing_count <= '0;
      trigger_count  <= '0;
    end else if (advance) begin
      gate_level     <= gate_level_next;
      delay_armed    <= delay_armed_next;
      elapsed_ticks  <= elapsed_ticks_next;
      target_delay   <= target_delay_next;
      crossing_count <= crossing_count_next;
      trigger_count  <= trigger_count_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_gate  <= gate_level_next;
      out_fired <= fired;
      out_cross <= TOTAL_WIDTH'(crossing_count_next);
      out_trig  <= TOTAL_WIDTH'(trigger_count_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_trig, out_cross, out_fired, out_gate};

endmodule
`default_nettype wire
